// ===== rtl/pesr_pkg.sv =====
// ----------------------------------------------------------------------------
// pesr_pkg
// Shared types, widths and codes for the equal-spacing polyline resampler.
// ----------------------------------------------------------------------------
package pesr_pkg;

    localparam int COORD_W   = 32;
    localparam int SPACING_W = 31;
    localparam int INDEX_W   = 10;

    localparam int MAX_PER_VERTEX_DEF = 16;
    localparam int MAX_POINTS_DEF     = 1024;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int SPACING_PCT        = 99;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 33;
    localparam int MUL_P_W    = 64;
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = 32;
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 33;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SPACING = 1'b0;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] pz;
        logic                      path_start;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qz;
        logic [INDEX_W-1:0]        point_index;
        logic                      last_of_run;
        logic                      truncated;
    } out_item_t;

    typedef struct packed {
        logic last;
        logic trunc;
        logic cont;
    } flush_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_A,
        ST_SQ_B,
        ST_ROOT,
        ST_DECIDE,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Z,
        ST_DIV_Z,
        ST_UPDATE,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/pesr_mul.sv =====
// ----------------------------------------------------------------------------
// pesr_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pesr_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pesr_pkg::MUL_A_W-1:0] a,
    input  logic [pesr_pkg::MUL_B_W-1:0] b,
    output logic                         done,
    output logic [pesr_pkg::MUL_P_W-1:0] product
);
    import pesr_pkg::*;

    localparam int ACC_W = MUL_A_W + MUL_B_W;
    localparam int CNT_W = $clog2(MUL_A_W);

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [MUL_B_W-1:0] b_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_B_W:0]   sum;

    always_comb begin
        sum      = {1'b0, acc_reg[ACC_W-1:MUL_A_W]} + (acc_reg[0] ? {1'b0, b_reg} : '0);
        acc_next = {sum, acc_reg[MUL_A_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_A_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= {{MUL_B_W{1'b0}}, a};
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg[MUL_P_W-1:0];

endmodule

// ===== rtl/pesr_sqrt.sv =====
// ----------------------------------------------------------------------------
// pesr_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pesr_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [pesr_pkg::SQRT_IN_W-1:0]  radicand,
    output logic                            done,
    output logic [pesr_pkg::SQRT_OUT_W-1:0] root
);
    import pesr_pkg::*;

    localparam int REM_W = SQRT_OUT_W + 2;
    localparam int TR_W  = REM_W + 2;
    localparam int CNT_W = $clog2(SQRT_OUT_W);

    logic [SQRT_IN_W-1:0]  rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [SQRT_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [TR_W-1:0]       trial;
    logic [TR_W-1:0]       tval;
    logic                  ge;

    always_comb begin
        trial = {rem_reg, rad_reg[SQRT_IN_W-1:SQRT_IN_W-2]};
        tval  = {2'b00, root_reg, 2'b01};
        ge    = trial >= tval;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_OUT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQRT_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(trial - tval) : REM_W'(trial);
            root_reg <= {root_reg[SQRT_OUT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/pesr_div.sv =====
// ----------------------------------------------------------------------------
// pesr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pesr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [pesr_pkg::DIV_N_W-1:0] numer,
    input  logic [pesr_pkg::DIV_D_W-1:0] denom,
    output logic                         done,
    output logic [pesr_pkg::DIV_N_W-1:0] quotient
);
    import pesr_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    always_comb begin
        trial = {rem_reg, num_reg[DIV_N_W-1]};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_N_W-2:0], ge};
            rem_reg <= ge ? DIV_D_W'(trial - {1'b0, den_reg}) : DIV_D_W'(trial);
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== rtl/polyline_equal_spacing_resampler_core.sv =====
// ----------------------------------------------------------------------------
// polyline_equal_spacing_resampler_core
// Resamples a stream of path vertices into points a fixed distance apart.
// ----------------------------------------------------------------------------
// Operation: each distance test runs two serial squares and a serial root;
// each emitted point adds two serial products and two serial divisions.
// Input: one vertex at a time; a path seed or ignored vertex is taken in idle.
// Reset: synchronous, active low; clears control state, spacing to 0.99.
module polyline_equal_spacing_resampler_core #(
    parameter int MAX_PER_VERTEX = pesr_pkg::MAX_PER_VERTEX_DEF,
    parameter int MAX_POINTS     = pesr_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS      = pesr_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pesr_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pesr_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pesr_pkg::PADDR_W-1:0] paddr,
    input  logic [pesr_pkg::PDATA_W-1:0] pwdata,
    output logic [pesr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import pesr_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NV_W  = $clog2(MAX_PER_VERTEX + 1);
    localparam logic [SPACING_W-1:0] SPACING_RESET =
        SPACING_W'((longint'(SPACING_PCT) << FRAC_BITS) / 100);

    state_t state_reg, state_next;
    logic   issue_reg;

    logic [SPACING_W-1:0] spacing_reg;
    logic                 started_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [NV_W-1:0]      nv_reg;
    logic                 pend_reg;
    logic                 m_valid_reg;
    flush_ctl_t           flush_reg;

    logic signed [COORD_W-1:0] vx_reg, vz_reg;
    logic signed [COORD_W-1:0] cur_x_reg, cur_z_reg, prev_x_reg, prev_z_reg;
    logic signed [COORD_W-1:0] newx_reg, newz_reg;
    logic [SPACING_W-1:0]      carried_reg;
    logic [SPACING_W-1:0]      ax_reg, az_reg;
    logic                      sh_reg;
    logic [MUL_P_W-1:0]        sq_reg;
    logic [DIV_D_W-1:0]        d_reg;
    logic [SPACING_W-1:0]      num_reg;
    logic [DIV_D_W-1:0]        den_reg;
    out_item_t                 pend_data_reg;
    out_item_t                 m_data_reg;

    logic [SPACING_W-1:0] sp;
    logic [SPACING_W-1:0] cprime;
    logic [COORD_W:0]     dcx, dcz, ncx, ncz, dpx, dpz, npx, npz;
    logic [COORD_W-1:0]   mdx, mdz, mpx, mpz;
    logic                 need_sh;
    logic                 d_lt;
    logic [CNT_W-1:0]     cnt_inc;

    logic accept, seed, go, rec, cap, emit, lim, out_free, fl_fire, cfg_wr;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               sqrt_start, sqrt_done;
    logic [SQRT_OUT_W-1:0] sqrt_root;
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_q;
    logic [COORD_W+1:0] new_val;

    pesr_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
    );

    pesr_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .radicand(sq_reg), .done(sqrt_done), .root(sqrt_root)
    );

    pesr_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .numer(mul_p), .denom(den_reg), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        sp      = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;
        dcx     = {cur_x_reg[COORD_W-1], cur_x_reg} - {vx_reg[COORD_W-1], vx_reg};
        dcz     = {cur_z_reg[COORD_W-1], cur_z_reg} - {vz_reg[COORD_W-1], vz_reg};
        ncx     = -dcx;
        ncz     = -dcz;
        mdx     = dcx[COORD_W] ? ncx[COORD_W-1:0] : dcx[COORD_W-1:0];
        mdz     = dcz[COORD_W] ? ncz[COORD_W-1:0] : dcz[COORD_W-1:0];
        need_sh = mdx[COORD_W-1] | mdz[COORD_W-1];
        dpx     = {vx_reg[COORD_W-1], vx_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dpz     = {vz_reg[COORD_W-1], vz_reg} - {prev_z_reg[COORD_W-1], prev_z_reg};
        npx     = -dpx;
        npz     = -dpz;
        mpx     = dpx[COORD_W] ? npx[COORD_W-1:0] : dpx[COORD_W-1:0];
        mpz     = dpz[COORD_W] ? npz[COORD_W-1:0] : dpz[COORD_W-1:0];
        d_lt    = d_reg < {2'b00, sp};
        cprime  = (carried_reg >= sp) ? sp - 1'b1 : carried_reg;
        cnt_inc = cnt_reg + 1'b1;
    end

    always_comb begin
        if (state_reg == ST_DIV_X) begin
            if (dpx[COORD_W]) begin
                new_val = {{2{prev_x_reg[COORD_W-1]}}, prev_x_reg} - {1'b0, div_q[COORD_W:0]};
            end else begin
                new_val = {{2{prev_x_reg[COORD_W-1]}}, prev_x_reg} + {1'b0, div_q[COORD_W:0]};
            end
        end else begin
            if (dpz[COORD_W]) begin
                new_val = {{2{prev_z_reg[COORD_W-1]}}, prev_z_reg} - {1'b0, div_q[COORD_W:0]};
            end else begin
                new_val = {{2{prev_z_reg[COORD_W-1]}}, prev_z_reg} + {1'b0, div_q[COORD_W:0]};
            end
        end
    end

    always_comb begin
        accept   = s_valid && s_ready;
        seed     = accept && (s_data.path_start || !started_reg);
        go       = accept && !seed && (cnt_reg < CNT_W'(MAX_POINTS));
        rec      = (state_reg == ST_DECIDE) && d_lt;
        cap      = (state_reg == ST_DECIDE) && !d_lt && (nv_reg >= NV_W'(MAX_PER_VERTEX));
        emit     = (state_reg == ST_DECIDE) && !rec && !cap;
        lim      = (state_reg == ST_UPDATE) && (cnt_inc >= CNT_W'(MAX_POINTS));
        out_free = !m_valid_reg || m_ready;
        fl_fire  = (state_reg == ST_FLUSH) && out_free;
        cfg_wr   = psel && penable && pwrite && pready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (go) state_next = ST_DIFF;
            end
            ST_DIFF:  state_next = ST_SQ_A;
            ST_SQ_A: begin
                if (mul_done) state_next = ST_SQ_B;
            end
            ST_SQ_B: begin
                if (mul_done) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_done) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (rec) begin
                    state_next = pend_reg ? ST_FLUSH : ST_IDLE;
                end else if (cap) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = pend_reg ? ST_FLUSH : ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                if (mul_done) state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (div_done) state_next = ST_MUL_Z;
            end
            ST_MUL_Z: begin
                if (mul_done) state_next = ST_DIV_Z;
            end
            ST_DIV_Z: begin
                if (div_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: state_next = lim ? ST_FLUSH : ST_DIFF;
            ST_FLUSH: begin
                if (out_free) state_next = flush_reg.cont ? ST_MUL_X : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        mul_start  = issue_reg && ((state_reg == ST_SQ_A) || (state_reg == ST_SQ_B) ||
                                   (state_reg == ST_MUL_X) || (state_reg == ST_MUL_Z));
        sqrt_start = issue_reg && (state_reg == ST_ROOT);
        div_start  = issue_reg && ((state_reg == ST_DIV_X) || (state_reg == ST_DIV_Z));
        case (state_reg)
            ST_SQ_B: begin
                mul_a = {1'b0, az_reg};
                mul_b = {2'b00, az_reg};
            end
            ST_MUL_X: begin
                mul_a = {1'b0, num_reg};
                mul_b = {1'b0, mpx};
            end
            ST_MUL_Z: begin
                mul_a = {1'b0, num_reg};
                mul_b = {1'b0, mpz};
            end
            default: begin
                mul_a = {1'b0, ax_reg};
                mul_b = {2'b00, ax_reg};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issue_reg   <= 1'b0;
            spacing_reg <= SPACING_RESET;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            nv_reg      <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            flush_reg   <= '0;
        end else begin
            state_reg <= state_next;
            issue_reg <= (state_next != state_reg);
            if (cfg_wr && (paddr[2] == REG_SPACING)) spacing_reg <= pwdata[SPACING_W-1:0];
            if (seed) begin
                started_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            if (go) nv_reg <= '0;
            if (state_reg == ST_UPDATE) begin
                cnt_reg  <= cnt_inc;
                nv_reg   <= nv_reg + 1'b1;
                pend_reg <= 1'b1;
            end
            if (fl_fire) begin
                pend_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (rec)  flush_reg <= '{last: 1'b1, trunc: 1'b0, cont: 1'b0};
            if (cap)  flush_reg <= '{last: 1'b1, trunc: 1'b1, cont: 1'b0};
            if (emit) flush_reg <= '{last: 1'b0, trunc: 1'b0, cont: 1'b1};
            if (lim)  flush_reg <= '{last: 1'b1, trunc: 1'b1, cont: 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            vx_reg <= s_data.px;
            vz_reg <= s_data.pz;
        end
        if (seed) begin
            cur_x_reg   <= s_data.px;
            prev_x_reg  <= s_data.px;
            cur_z_reg   <= s_data.pz;
            prev_z_reg  <= s_data.pz;
            carried_reg <= '0;
        end
        if (state_reg == ST_DIFF) begin
            sh_reg <= need_sh;
            ax_reg <= need_sh ? mdx[COORD_W-1:1] : mdx[SPACING_W-1:0];
            az_reg <= need_sh ? mdz[COORD_W-1:1] : mdz[SPACING_W-1:0];
        end
        if ((state_reg == ST_SQ_A) && mul_done) sq_reg <= mul_p;
        if ((state_reg == ST_SQ_B) && mul_done) sq_reg <= sq_reg + mul_p;
        if ((state_reg == ST_ROOT) && sqrt_done) begin
            d_reg <= sh_reg ? {sqrt_root, 1'b0} : {1'b0, sqrt_root};
        end
        if (rec) begin
            carried_reg <= d_reg[SPACING_W-1:0];
            prev_x_reg  <= vx_reg;
            prev_z_reg  <= vz_reg;
        end
        if (cap) begin
            cur_x_reg   <= vx_reg;
            prev_x_reg  <= vx_reg;
            cur_z_reg   <= vz_reg;
            prev_z_reg  <= vz_reg;
            carried_reg <= '0;
        end
        if (emit) begin
            num_reg <= sp - cprime;
            den_reg <= d_reg - {2'b00, cprime};
        end
        if ((state_reg == ST_DIV_X) && div_done) newx_reg <= new_val[COORD_W-1:0];
        if ((state_reg == ST_DIV_Z) && div_done) newz_reg <= new_val[COORD_W-1:0];
        if (state_reg == ST_UPDATE) begin
            cur_x_reg   <= newx_reg;
            prev_x_reg  <= newx_reg;
            cur_z_reg   <= newz_reg;
            prev_z_reg  <= newz_reg;
            carried_reg <= '0;
            pend_data_reg <= '{qx: newx_reg, qz: newz_reg, point_index: INDEX_W'(cnt_reg),
                               last_of_run: 1'b0, truncated: 1'b0};
        end
        if (fl_fire) begin
            m_data_reg <= '{qx: pend_data_reg.qx, qz: pend_data_reg.qz,
                            point_index: pend_data_reg.point_index,
                            last_of_run: flush_reg.last, truncated: flush_reg.trunc};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_SPACING) ? {1'b0, spacing_reg} : '0;

    a_ready_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_reg)
        else $error("input taken while a point is pending");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("emitted count beyond limit");

    a_nv_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nv_reg <= NV_W'(MAX_PER_VERTEX))
        else $error("per-vertex count beyond cap");

    a_flush_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        fl_fire |=> m_valid)
        else $error("flush did not present a transaction");

endmodule
